[design/pqbd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqbd_pkg
// Shared widths, item codes and inter-module control types for the packet
// queue with byte-budget dequeue.
// ----------------------------------------------------------------------------
package pqbd_pkg;

	localparam int QUEUE_DEPTH_DEF = 64;

	localparam int LEN_W  = 16;
	localparam int BPB_W  = 10;
	localparam int BLK_W  = 8;
	localparam int SENT_W = 18;
	localparam int USED_W = 8;
	localparam int STEP_W = $clog2(USED_W);

	localparam logic KIND_ENQUEUE = 1'b0;
	localparam logic KIND_GRANT   = 1'b1;

	typedef struct packed {
		logic              start;
		logic [SENT_W-1:0] dividend;
		logic [BPB_W-1:0]  divisor;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [USED_W-1:0] quotient;
	} div_rsp_t;

endpackage

[design/pqbd_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqbd channel interfaces
// Valid/ready channels for queue items and per-item results.
// ----------------------------------------------------------------------------
interface pqbd_in_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic [pqbd_pkg::LEN_W-1:0] packet_length;
	logic [pqbd_pkg::BPB_W-1:0] bytes_per_block;
	logic [pqbd_pkg::BLK_W-1:0] blocks_available;

	modport source (output valid, kind, packet_length, bytes_per_block,
		blocks_available, input ready);
	modport sink (input valid, kind, packet_length, bytes_per_block,
		blocks_available, output ready);
endinterface

interface pqbd_out_if #(
	parameter int QUEUE_DEPTH = pqbd_pkg::QUEUE_DEPTH_DEF
);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic                        valid;
	logic                        ready;
	logic [CNT_W-1:0]            queue_length;
	logic [pqbd_pkg::SENT_W-1:0] bytes_sent;
	logic [pqbd_pkg::USED_W-1:0] blocks_used;
	logic                        dropped;

	modport source (output valid, queue_length, bytes_sent, blocks_used, dropped,
		input ready);
	modport sink (input valid, queue_length, bytes_sent, blocks_used, dropped,
		output ready);
endinterface

[design/pqbd_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqbd_store
// Packet length memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module pqbd_store #(
	parameter int QUEUE_DEPTH = pqbd_pkg::QUEUE_DEPTH_DEF,
	localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [PTR_W-1:0]           waddr,
	input  logic [pqbd_pkg::LEN_W-1:0] wdata,
	input  logic [PTR_W-1:0]           raddr,
	output logic [pqbd_pkg::LEN_W-1:0] rdata
);

	logic [pqbd_pkg::LEN_W-1:0] mem_q [QUEUE_DEPTH];
	logic [pqbd_pkg::LEN_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[design/pqbd_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pqbd_divider
// Restoring divider, one quotient bit per cycle, for a quotient that fits
// in USED_W bits.
// ----------------------------------------------------------------------------
module pqbd_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  pqbd_pkg::div_req_t req,
	output pqbd_pkg::div_rsp_t rsp
);

	logic [pqbd_pkg::SENT_W-1:0] rem_q;
	logic [pqbd_pkg::BPB_W-1:0]  div_q;
	logic [pqbd_pkg::USED_W-1:0] quo_q;
	logic [pqbd_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;
	logic                        done_q;
	logic [pqbd_pkg::SENT_W-1:0] shifted;
	logic                        ge;

	assign shifted = pqbd_pkg::SENT_W'(div_q) << step_q;
	assign ge      = rem_q >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
			end else if (busy_q && step_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.dividend;
			div_q  <= req.divisor;
			quo_q  <= '0;
			step_q <= pqbd_pkg::STEP_W'(pqbd_pkg::USED_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				rem_q         <= rem_q - shifted;
				quo_q[step_q] <= 1'b1;
			end
			if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = quo_q;

endmodule

[design/packet_queue_byte_budget_dequeue_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_queue_byte_budget_dequeue_core
// Packet length FIFO with a grant that dequeues head packets against a byte
// budget and reports bytes sent and resource blocks used.
// ----------------------------------------------------------------------------
// One item is handled at a time and each gives exactly one result. An enqueue
// goes straight from transfer to the result state. A grant first walks the
// queue head, and the walk removes one packet per cycle through the
// single read port of the length memory, then the ceiling of bytes over bytes
// per block comes from an 8-step divider. Grants with zero bytes per block
// skip the divider. A new item is taken once the previous result has been
// loaded into the output register.
module packet_queue_byte_budget_dequeue_core #(
	parameter int QUEUE_DEPTH = pqbd_pkg::QUEUE_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	pqbd_in_if.sink        ingress,
	pqbd_out_if.source     egress
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_RESP
	} state_t;

	state_t                      state_q;
	logic [PTR_W-1:0]            head_q;
	logic [PTR_W-1:0]            tail_q;
	logic [CNT_W-1:0]            count_q;
	logic [pqbd_pkg::SENT_W-1:0] budget_q;
	logic [pqbd_pkg::SENT_W-1:0] sent_q;
	logic [pqbd_pkg::BPB_W-1:0]  bpb_q;
	logic [pqbd_pkg::USED_W-1:0] used_q;
	logic                        drop_q;

	logic                        out_valid_q;
	logic [CNT_W-1:0]            out_len_q;
	logic [pqbd_pkg::SENT_W-1:0] out_sent_q;
	logic [pqbd_pkg::USED_W-1:0] out_used_q;
	logic                        out_drop_q;

	logic                        accept;
	logic                        full;
	logic                        wr_en;
	logic [pqbd_pkg::LEN_W-1:0]  rd_len;
	logic [PTR_W-1:0]            head_adv;
	logic [PTR_W-1:0]            tail_adv;
	logic [PTR_W-1:0]            rd_addr;
	logic                        pop;
	logic                        out_free;
	pqbd_pkg::div_req_t          div_req;
	pqbd_pkg::div_rsp_t          div_rsp;

	assign ingress.ready = (state_q == ST_IDLE);
	assign accept        = ingress.valid && ingress.ready;
	assign full          = (count_q == CNT_W'(QUEUE_DEPTH));
	assign wr_en         = accept && ingress.kind == pqbd_pkg::KIND_ENQUEUE && !full;

	assign head_adv = (head_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign tail_adv = (tail_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;

	// head removal during the walk
	assign pop = (state_q == ST_WALK) && count_q != '0 && budget_q != '0
		&& pqbd_pkg::SENT_W'(rd_len) <= budget_q;
	assign rd_addr = pop ? head_adv : head_q;

	assign div_req.start    = (state_q == ST_WALK) && !pop && bpb_q != '0;
	assign div_req.dividend = pqbd_pkg::SENT_W'(sent_q + pqbd_pkg::SENT_W'(bpb_q)
		- pqbd_pkg::SENT_W'(1));
	assign div_req.divisor  = bpb_q;

	assign out_free = !out_valid_q || egress.ready;

	pqbd_store #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (wr_en),
		.waddr (tail_q),
		.wdata (ingress.packet_length),
		.raddr (rd_addr),
		.rdata (rd_len)
	);

	pqbd_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && egress.ready && state_q != ST_RESP) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						sent_q <= '0;
						used_q <= '0;
						if (ingress.kind == pqbd_pkg::KIND_ENQUEUE) begin
							drop_q <= full;
							if (!full) begin
								tail_q  <= tail_adv;
								count_q <= count_q + 1'b1;
							end
							state_q <= ST_RESP;
						end else begin
							drop_q   <= 1'b0;
							bpb_q    <= ingress.bytes_per_block;
							budget_q <= pqbd_pkg::SENT_W'(
								pqbd_pkg::SENT_W'(ingress.bytes_per_block)
								* pqbd_pkg::SENT_W'(ingress.blocks_available));
							state_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					if (pop) begin
						budget_q <= budget_q - pqbd_pkg::SENT_W'(rd_len);
						sent_q   <= sent_q + pqbd_pkg::SENT_W'(rd_len);
						head_q   <= head_adv;
						count_q  <= count_q - 1'b1;
					end else if (bpb_q != '0) begin
						state_q <= ST_DIV;
					end else begin
						state_q <= ST_RESP;
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						used_q  <= div_rsp.quotient;
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_len_q   <= count_q;
						out_sent_q  <= sent_q;
						out_used_q  <= used_q;
						out_drop_q  <= drop_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign egress.valid        = out_valid_q;
	assign egress.queue_length = out_len_q;
	assign egress.bytes_sent   = out_sent_q;
	assign egress.blocks_used  = out_used_q;
	assign egress.dropped      = out_drop_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || count_q == CNT_W'(QUEUE_DEPTH)) |-> head_q == tail_q)
		else $error("pointers disagree with empty or full count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(egress.valid && egress.dropped) |-> egress.queue_length == CNT_W'(QUEUE_DEPTH))
		else $error("drop reported with queue not full");

	a_blocks_need_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		(egress.valid && egress.blocks_used != '0) |-> egress.bytes_sent != '0)
		else $error("blocks used without bytes sent");

	a_budget_falls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK) |=> budget_q <= $past(budget_q))
		else $error("budget grew during walk");
`endif

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for packet_queue_byte_budget_dequeue_core. It sends
// enqueue and grant items over the ingress channel. A scoreboard class keeps
// its own copy of the packet length FIFO and works out the expected queue
// length, bytes sent, blocks used and drop flag for every accepted item. It
// then checks each egress transfer in order against that expectation. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

	localparam int DEPTH         = pqbd_pkg::QUEUE_DEPTH_DEF;
	localparam int CNT_W         = $clog2(DEPTH + 1);
	localparam int LEN_W         = pqbd_pkg::LEN_W;
	localparam int BPB_W         = pqbd_pkg::BPB_W;
	localparam int BLK_W         = pqbd_pkg::BLK_W;
	localparam int SENT_W        = pqbd_pkg::SENT_W;
	localparam int USED_W        = pqbd_pkg::USED_W;
	localparam int ITEM_TARGET   = 550;
	localparam int IDLE_LIMIT    = 2000;
	localparam int SETTLE_CYCLES = 100;

	typedef enum {PHASE_FILL, PHASE_MIXED, PHASE_DRAIN} phase_mode_t;

	typedef struct {
		logic             kind;
		logic [LEN_W-1:0] packet_length;
		logic [BPB_W-1:0] bytes_per_block;
		logic [BLK_W-1:0] blocks_available;
	} queue_item_t;

	typedef struct {
		logic [CNT_W-1:0]  queue_length;
		logic [SENT_W-1:0] bytes_sent;
		logic [USED_W-1:0] blocks_used;
		logic              dropped;
	} queue_outcome_t;

	class queue_tracker;
		logic [LEN_W-1:0] held_lengths[$];
		queue_outcome_t   pending_outcomes[$];
		int errors;
		int n_enqueue;
		int n_drop;
		int n_grant;
		int n_zero_budget;
		int n_removed;
		int n_blocked;
		int n_checked;

		function void note_transfer(queue_item_t it);
			queue_outcome_t want;
			int budget;
			int sent;
			want = '{default: '0};
			if (it.kind == pqbd_pkg::KIND_ENQUEUE) begin
				n_enqueue++;
				if (held_lengths.size() >= DEPTH) begin
					want.dropped = 1'b1;
					n_drop++;
				end else begin
					held_lengths.push_back(it.packet_length);
				end
			end else begin
				n_grant++;
				budget = int'(it.bytes_per_block) * int'(it.blocks_available);
				sent = 0;
				if (budget == 0)
					n_zero_budget++;
				while (budget > 0 && held_lengths.size() > 0) begin
					if (int'(held_lengths[0]) > budget) begin
						n_blocked++;
						break;
					end
					budget -= int'(held_lengths[0]);
					sent += int'(held_lengths.pop_front());
					n_removed++;
				end
				want.bytes_sent = SENT_W'(sent);
				if (it.bytes_per_block != 0)
					want.blocks_used = USED_W'((sent + int'(it.bytes_per_block) - 1) /
						int'(it.bytes_per_block));
			end
			want.queue_length = CNT_W'(held_lengths.size());
			pending_outcomes.push_back(want);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_outcome(queue_outcome_t got);
			queue_outcome_t want;
			if (pending_outcomes.size() == 0) begin
				$display("%0t: result with nothing expected, queue_length %0d bytes_sent %0d",
					$time, got.queue_length, got.bytes_sent);
				errors++;
				return;
			end
			want = pending_outcomes.pop_front();
			n_checked++;
			check_field("queue_length", 32'(want.queue_length), 32'(got.queue_length));
			check_field("bytes_sent", 32'(want.bytes_sent), 32'(got.bytes_sent));
			check_field("blocks_used", 32'(want.blocks_used), 32'(got.blocks_used));
			check_field("dropped", 32'(want.dropped), 32'(got.dropped));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	pqbd_in_if in_ch ();
	pqbd_out_if #(.QUEUE_DEPTH(DEPTH)) out_ch ();

	packet_queue_byte_budget_dequeue_core #(
		.QUEUE_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.ingress(in_ch),
		.egress(out_ch)
	);

	queue_tracker tracker = new();
	bit tx_idle_on;
	bit rx_idle_on;
	int items_done;
	int idle_cycles;

	always #10 clk = ~clk;

	function automatic int pick_gap(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic queue_item_t random_item(int enqueue_pct);
		queue_item_t it;
		int r;
		it.kind = ($urandom_range(1, 100) <= enqueue_pct) ? pqbd_pkg::KIND_ENQUEUE :
			pqbd_pkg::KIND_GRANT;
		it.packet_length = LEN_W'($urandom);
		it.bytes_per_block = BPB_W'($urandom);
		it.blocks_available = BLK_W'($urandom);
		if (it.kind == pqbd_pkg::KIND_ENQUEUE) begin
			r = $urandom_range(0, 99);
			if (r < 10)
				it.packet_length = '0;
			else if (r < 15)
				it.packet_length = '1;
			else if (r >= 30)
				it.packet_length = LEN_W'($urandom_range(1, 3000));
		end else begin
			r = $urandom_range(0, 99);
			if (r < 5)
				it.bytes_per_block = '0;
			else if (r < 10)
				it.bytes_per_block = '1;
			else if (r < 15)
				it.bytes_per_block = BPB_W'(1);
			r = $urandom_range(0, 99);
			if (r < 8)
				it.blocks_available = '0;
			else if (r < 14)
				it.blocks_available = '1;
			else if (r < 45)
				it.blocks_available = BLK_W'($urandom_range(1, 8));
		end
		return it;
	endfunction

	task automatic push_item(queue_item_t it);
		int gap;
		gap = pick_gap(tx_idle_on);
		@(negedge clk);
		if (gap > 0) begin
			in_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.kind = it.kind;
		in_ch.packet_length = it.packet_length;
		in_ch.bytes_per_block = it.bytes_per_block;
		in_ch.blocks_available = it.blocks_available;
		do @(posedge clk); while (!in_ch.ready);
		tracker.note_transfer(it);
		items_done++;
	endtask

	task automatic enqueue(logic [LEN_W-1:0] len);
		push_item('{pqbd_pkg::KIND_ENQUEUE, len, BPB_W'($urandom), BLK_W'($urandom)});
	endtask

	task automatic grant(logic [BPB_W-1:0] bpb, logic [BLK_W-1:0] blocks);
		push_item('{pqbd_pkg::KIND_GRANT, LEN_W'($urandom), bpb, blocks});
	endtask

	// hold the ingress side until every expected result has come back
	task automatic wait_for_results();
		@(negedge clk);
		in_ch.valid = 1'b0;
		while (tracker.pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				out_ch.ready = 1'b0;
				stall_left--;
			end else begin
				out_ch.ready = 1'b1;
				stall_left = pick_gap(rx_idle_on);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready)
			tracker.check_outcome(queue_outcome_t'{out_ch.queue_length, out_ch.bytes_sent,
				out_ch.blocks_used, out_ch.dropped});
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
					IDLE_LIMIT, tracker.pending_outcomes.size());
				$display("testbench: FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		phase_mode_t mode;
		int phase_len;
		int enqueue_pct;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.kind = pqbd_pkg::KIND_ENQUEUE;
		in_ch.packet_length = '0;
		in_ch.bytes_per_block = '0;
		in_ch.blocks_available = '0;
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		items_done = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// grant on an empty queue
		grant(1, 1);
		// zero-length and longest packets
		enqueue('0);
		enqueue('1);
		// zero bytes per block, then zero blocks: nothing leaves, not even length zero
		grant('0, '1);
		grant('1, '0);
		// zero-length head leaves, then the longest head does not fit
		grant(1, 1);
		// largest budget takes the longest packet
		grant('1, '1);
		// budget used up exactly, the next head waits
		enqueue(1000);
		enqueue(1000);
		enqueue(1);
		grant(500, 4);
		grant(1, 1);
		// alternating bit patterns
		enqueue(16'h5555);
		enqueue(16'haaaa);
		grant(10'h2aa, 8'haa);
		grant(10'h155, 8'h55);
		wait_for_results();

		// fill past full so that drops happen, then empty the queue again
		tx_idle_on = 1'b0;
		repeat (DEPTH + 6) push_item(random_item(100));
		wait_for_results();
		tx_idle_on = 1'b1;
		repeat (4) grant('1, '1);

		while (items_done < ITEM_TARGET) begin
			mode = phase_mode_t'($urandom_range(0, 2));
			phase_len = $urandom_range(15, 70);
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			case (mode)
				PHASE_FILL:  enqueue_pct = 85;
				PHASE_MIXED: enqueue_pct = 50;
				default:     enqueue_pct = 25;
			endcase
			repeat (phase_len) push_item(random_item(enqueue_pct));
			if ($urandom_range(0, 3) == 0)
				wait_for_results();
		end

		wait_for_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (tracker.pending_outcomes.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time,
				tracker.pending_outcomes.size());
			tracker.errors++;
		end
		$display("run covered %0d enqueues (%0d dropped on a full queue), %0d grants %s",
			tracker.n_enqueue, tracker.n_drop, tracker.n_grant, "in total");
		$display("%0d grants had no budget, %0d packets dequeued, %0d %s, %0d results checked",
			tracker.n_zero_budget, tracker.n_removed, tracker.n_blocked,
			"grants stopped at an oversized head", tracker.n_checked);
		if (tracker.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule

[packet_queue_byte_budget_dequeue_core.f]
design/pqbd_pkg.sv
design/pqbd_ifs.sv
design/pqbd_store.sv
design/pqbd_divider.sv
design/packet_queue_byte_budget_dequeue_core.sv
bench/testbench.sv
